[rtl/core/assert_macros.svh]
// Concurrent assertion helpers shared by lse_ctrl and lse_dpath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define LSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define LSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define LSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/lse_pkg.sv]
`default_nettype none

package lse_pkg;

	localparam int SENSORS_PER_ROW_DEF = 6;
	localparam int SAMPLE_BITS_DEF     = 12;
	localparam int SENSOR_W            = 3;
	localparam int SCALE               = 1000;
	localparam int SCALE_W             = 10;
	localparam int SUM_W               = 27;
	localparam int OUT_W               = 26;

	localparam logic OP_CAL    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;
	localparam logic ROW_LEFT  = 1'b0;
	localparam logic ROW_RIGHT = 1'b1;

	typedef struct packed {
		logic req_valid;
		logic req_cal;
		logic req_ok;
		logic req_last;
		logic item_last;
		logic div_done;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic accept;
		logic ram_we;
		logic capture;
		logic clamp;
		logic load;
		logic div_step;
		logic acc;
		logic emit;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/core/lse_in_if.sv]
`default_nettype none

interface lse_in_if #(
	parameter int SAMPLE_BITS = lse_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic                          row;
	logic [lse_pkg::SENSOR_W-1:0]  sensor;
	logic [SAMPLE_BITS-1:0]        value;
	logic [SAMPLE_BITS-1:0]        cal_max;
	logic                          last;

	modport source (output valid, op, row, sensor, value, cal_max, last, input ready);
	modport sink   (input valid, op, row, sensor, value, cal_max, last, output ready);
endinterface

`default_nettype wire

[rtl/core/lse_out_if.sv]
`default_nettype none

interface lse_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [lse_pkg::OUT_W-1:0]  line_error;

	modport source (output valid, line_error, input ready);
	modport sink   (input valid, line_error, output ready);
endinterface

`default_nettype wire

[rtl/core/line_sensor_error.sv]
// channel  dir  interface   payload
// item     in   lse_in_if   op, row, sensor, value, cal_max, last
// result   out  lse_out_if  line_error
//
// A calibration transaction and a sample with a sensor out of range are handled in the idle step.
// A sample in range steps through table read, clamp, scale, then the restoring divider
// at one quotient bit per cycle, then accumulate.
// A sample marked last then goes to the emit step, which loads the output register.
// arst_n clears the controller, the frame sum and the output valid; the table is not cleared.
// A full output register that is not taken holds the block in its emit step.
`default_nettype none

module line_sensor_error #(
	parameter int SENSORS_PER_ROW = lse_pkg::SENSORS_PER_ROW_DEF,
	parameter int SAMPLE_BITS     = lse_pkg::SAMPLE_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lse_in_if.sink    item,
	lse_out_if.source result
);

	lse_pkg::cmd_t cmd;
	lse_pkg::sts_t sts;

	lse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	lse_dpath #(
		.SENSORS_PER_ROW (SENSORS_PER_ROW),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.item   (item),
		.result (result)
	);

endmodule

`default_nettype wire

[rtl/core/lse_ram.sv]
`default_nettype none

module lse_ram #(
	parameter int WIDTH = 2 * lse_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH = 2 * lse_pkg::SENSORS_PER_ROW_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr_w,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr_r,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_w] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr_r];
		end
	end

endmodule

`default_nettype wire

[rtl/core/lse_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"

module lse_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lse_pkg::sts_t sts,
	output lse_pkg::cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CLAMP = 6'b000010,
		S_MUL   = 6'b000100,
		S_DIV   = 6'b001000,
		S_ACC   = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = 1'b1;
				if (sts.req_valid) begin
					cmd.capture = 1'b1;
					if (sts.req_cal) begin
						cmd.ram_we = sts.req_ok;
					end else if (sts.req_ok) begin
						state_d = S_CLAMP;
					end else if (sts.req_last) begin
						state_d = S_EMIT;
					end
				end
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = S_MUL;
			end
			S_MUL: begin
				cmd.load = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.item_last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				// hold until the output register can take the transaction
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`LSE_ASSERT_NXT(a_sample_starts, clk, arst_n,
		state_q == S_IDLE && sts.req_valid && !sts.req_cal && sts.req_ok, state_q == S_CLAMP)
	`LSE_ASSERT_NXT(a_div_exits, clk, arst_n,
		state_q == S_DIV && sts.div_done, state_q == S_ACC)
	`LSE_ASSERT_NXT(a_emit_returns, clk, arst_n,
		state_q == S_EMIT && sts.out_free, state_q == S_IDLE)

endmodule

`default_nettype wire

[rtl/core/lse_dpath.sv]
`default_nettype none
`include "assert_macros.svh"

module lse_dpath #(
	parameter int SENSORS_PER_ROW = lse_pkg::SENSORS_PER_ROW_DEF,
	parameter int SAMPLE_BITS     = lse_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lse_pkg::cmd_t cmd,
	output lse_pkg::sts_t      sts,
	lse_in_if.sink             item,
	lse_out_if.source          result
);

	localparam int ENTRIES = 2 * SENSORS_PER_ROW;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int SB      = SAMPLE_BITS;
	localparam int NW      = SB + lse_pkg::SCALE_W;
	localparam int CNT_W   = $clog2(NW);
	localparam int SUM_W   = lse_pkg::SUM_W;
	localparam int OUT_W   = lse_pkg::OUT_W;
	localparam int ACC_W   = SUM_W + 2;
	localparam int SEN_W   = lse_pkg::SENSOR_W + 1;

	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'((1 << (SUM_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-(1 << (SUM_W - 1)));
	localparam logic signed [SUM_W-1:0] OUT_HI = SUM_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] OUT_LO = SUM_W'(-(1 << (OUT_W - 1)));

	// input decode
	logic [SEN_W-1:0]  sensor_ext;
	logic [SEN_W-1:0]  idx_full;
	logic [IDX_W-1:0]  idx;
	logic              sensor_ok;

	assign sensor_ext = {1'b0, item.sensor};
	assign sensor_ok  = sensor_ext < SEN_W'(SENSORS_PER_ROW);
	assign idx_full   = (item.row == lse_pkg::ROW_RIGHT) ?
		sensor_ext + SEN_W'(SENSORS_PER_ROW) : sensor_ext;
	assign idx        = idx_full[IDX_W-1:0];

	// calibration table: {max, min}
	logic [2*SB-1:0] cal_rd;

	lse_ram #(
		.WIDTH (2 * SB),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk    (clk),
		.we     (cmd.ram_we),
		.addr_w (idx),
		.wdata  ({item.cal_max, item.value}),
		.re     (cmd.capture),
		.addr_r (idx),
		.rdata  (cal_rd)
	);

	// captured item
	logic [SB-1:0] sample_q;
	logic          row_q;
	logic          last_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= item.value;
			row_q    <= item.row;
			last_q   <= item.last;
		end
	end

	// clamp and range
	logic [SB-1:0]        mx;
	logic [SB-1:0]        mn;
	logic [SB-1:0]        s_clamp;
	logic signed [SB:0]   rng;
	logic [SB:0]          rng_neg;
	logic [SB-1:0]        rng_mag;
	logic [SB-1:0]        dvs;

	assign mx = cal_rd[2*SB-1:SB];
	assign mn = cal_rd[SB-1:0];

	always_comb begin
		s_clamp = sample_q;
		if (s_clamp >= mx) begin
			s_clamp = mx;
		end
		if (s_clamp <= mn) begin
			s_clamp = mn;
		end
	end

	assign rng     = $signed({1'b0, mx}) - $signed({1'b0, mn});
	assign rng_neg = -rng;
	assign rng_mag = rng[SB] ? rng_neg[SB-1:0] : rng[SB-1:0];
	assign dvs     = (rng_mag == '0) ? SB'(1) : rng_mag;

	logic [SB-1:0] s_q;
	logic [SB-1:0] dvs_q;
	logic          neg_q;

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			s_q   <= s_clamp;
			dvs_q <= dvs;
			neg_q <= rng[SB];
		end
	end

	// scale, then restoring divide one quotient bit per cycle
	logic [NW-1:0]  prod;
	logic [NW-1:0]  quo_q;
	logic [SB-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SB:0]    rem_sh;
	logic [SB:0]    diff;

	assign prod   = NW'(s_q) * NW'(lse_pkg::SCALE);
	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= prod;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[NW-2:0], !diff[SB]};
			rem_q <= diff[SB] ? rem_sh[SB-1:0] : diff[SB-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// frame accumulator with saturation
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ACC_W-1:0] sum_ext;
	logic signed [ACC_W-1:0] mag_ext;
	logic signed [ACC_W-1:0] acc_raw;
	logic signed [SUM_W-1:0] acc_sat;
	logic                    sub;

	assign sum_ext = ACC_W'(sum_q);
	assign mag_ext = $signed(ACC_W'(quo_q));
	assign sub     = neg_q ^ (row_q == lse_pkg::ROW_LEFT);
	assign acc_raw = sub ? sum_ext - mag_ext : sum_ext + mag_ext;

	always_comb begin
		if (acc_raw > ACC_HI) begin
			acc_sat = ACC_HI[SUM_W-1:0];
		end else if (acc_raw < ACC_LO) begin
			acc_sat = ACC_LO[SUM_W-1:0];
		end else begin
			acc_sat = acc_raw[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.emit) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= acc_sat;
		end
	end

	// output register
	logic signed [OUT_W-1:0] out_sat;
	logic signed [OUT_W-1:0] line_error_q;
	logic                    out_valid_q;

	always_comb begin
		if (sum_q > OUT_HI) begin
			out_sat = OUT_HI[OUT_W-1:0];
		end else if (sum_q < OUT_LO) begin
			out_sat = OUT_LO[OUT_W-1:0];
		end else begin
			out_sat = sum_q[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			line_error_q <= out_sat;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.line_error = line_error_q;
	assign item.ready        = cmd.accept;

	assign sts.req_valid = item.valid;
	assign sts.req_cal   = item.op == lse_pkg::OP_CAL;
	assign sts.req_ok    = sensor_ok;
	assign sts.req_last  = item.last;
	assign sts.item_last = last_q;
	assign sts.div_done  = cnt_q == CNT_W'(NW - 1);
	assign sts.out_free  = !out_valid_q || result.ready;

	`LSE_ASSERT_NXT(a_clear_after_emit, clk, arst_n, cmd.emit, sum_q == '0)
	`LSE_ASSERT_IMP(a_divisor_nonzero, clk, arst_n, cmd.div_step, dvs_q != '0)
	`LSE_ASSERT_IMP(a_result_from_emit, clk, arst_n, $rose(out_valid_q), $past(cmd.emit))

endmodule

`default_nettype wire

[test/lse_error_checker.sv]
`timescale 1ns / 100ps

module lse_error_checker
	import lse_pkg::*;
#(
	parameter int SPR = SENSORS_PER_ROW_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lse_in_if    item_mon,
	lse_out_if   result_mon,
	output int   fail_count,
	output int   pending
);

	localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));
	localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_LO = -(longint'(1) <<< (OUT_W - 1));

	logic [11:0] lo_tab [2*SPR];
	logic [11:0] hi_tab [2*SPR];
	longint frame_acc;
	logic signed [OUT_W-1:0] err_q [$];

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint scaled_term(input int idx, input logic [11:0] sample);
		longint mx, mn, s, span;
		mx = longint'(hi_tab[idx]);
		mn = longint'(lo_tab[idx]);
		s = longint'(sample);
		if (s >= mx)
			s = mx;
		if (s <= mn)
			s = mn;
		span = mx - mn;
		if (span == 0)
			span = 1;
		return (s * SCALE) / span;
	endfunction

	task automatic report(input string what, input logic signed [OUT_W-1:0] got,
			input logic signed [OUT_W-1:0] want);
		$display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic take_item();
		int idx;
		longint t;
		idx = int'(item_mon.row) * SPR + int'(item_mon.sensor);
		if (item_mon.op == OP_CAL) begin
			if (item_mon.sensor < SPR) begin
				lo_tab[idx] = item_mon.value;
				hi_tab[idx] = item_mon.cal_max;
			end
		end else begin
			if (item_mon.sensor < SPR) begin
				t = scaled_term(idx, item_mon.value);
				frame_acc = clip(item_mon.row == ROW_RIGHT ? frame_acc + t : frame_acc - t,
						SUM_LO, SUM_HI);
			end
			if (item_mon.last) begin
				err_q.push_back(OUT_W'(clip(frame_acc, OUT_LO, OUT_HI)));
				frame_acc = 0;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			frame_acc = 0;
			err_q.delete();
			fail_count = 0;
		end else begin
			if (item_mon.valid && item_mon.ready)
				take_item();
			if (result_mon.valid && result_mon.ready) begin
				if (err_q.size() == 0)
					report("line_error with nothing expected", result_mon.line_error, '0);
				else if (result_mon.line_error !== err_q[0]) begin
					report("line_error", result_mon.line_error, err_q[0]);
					void'(err_q.pop_front());
				end else
					void'(err_q.pop_front());
			end
		end
		pending <= err_q.size();
	end

endmodule

[test/line_sensor_error_tb.sv]
`timescale 1ns / 100ps

module line_sensor_error_tb;
	import lse_pkg::*;

	localparam int SPR = SENSORS_PER_ROW_DEF;
	localparam int DIRECTED = 24;
	localparam int RANDOM_ITEMS = 500;
	localparam int LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_cnt = 0;
	int   src_idle = 0;
	int   sink_stall = 0;
	int   items_sent = 0;
	bit   [2*SPR-1:0] cal_seen = '0;

	logic [11:0] dir_lo [2*SPR] = '{12'd0, 12'hFFF, 12'hFFF, 12'd100, 12'd2048, 12'd0,
			12'hFFF, 12'hFFF, 12'd0, 12'd1000, 12'd3000, 12'd500};
	logic [11:0] dir_hi [2*SPR] = '{12'hFFF, 12'hFFF, 12'd0, 12'd3000, 12'd2049, 12'd0,
			12'hFFF, 12'd0, 12'hFFF, 12'd1000, 12'd100, 12'd600};

	lse_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) item_ch ();
	lse_out_if result_ch ();

	line_sensor_error u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	lse_error_checker #(.SPR(SPR)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_mon   (item_ch),
		.result_mon (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= sink_stall);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input logic op, input logic row, input logic [2:0] k,
			input logic [11:0] v, input logic [11:0] mx, input logic lst);
		while ($urandom_range(99) < src_idle) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.op      <= op;
		item_ch.row     <= row;
		item_ch.sensor  <= k;
		item_ch.value   <= v;
		item_ch.cal_max <= mx;
		item_ch.last    <= lst;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (!(op == OP_CAL && k >= SPR))
			items_sent++;
	endtask

	task automatic calib(input logic row, input logic [2:0] k, input logic [11:0] lo,
			input logic [11:0] hi, input logic lst);
		send_item(OP_CAL, row, k, lo, hi, lst);
		if (k < SPR)
			cal_seen[int'(row) * SPR + int'(k)] = 1'b1;
	endtask

	initial begin
		int kind, len, n;
		logic r, r0;
		bit one_row;
		logic [2:0] k;
		logic [11:0] lo, hi, v;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_CAL;
		item_ch.row = ROW_LEFT;
		item_ch.sensor = '0;
		item_ch.value = '0;
		item_ch.cal_max = '0;
		item_ch.last = 1'b0;
		result_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		calib(ROW_LEFT, 3'd6, 12'hFFF, 12'hFFF, 1'b1);
		calib(ROW_RIGHT, 3'd7, 12'd0, 12'd0, 1'b0);
		for (int i = 0; i < 2 * SPR; i++)
			calib(i >= SPR, 3'(i % SPR), dir_lo[i], dir_hi[i], i == 2 * SPR - 1);

		send_item(OP_SAMPLE, ROW_LEFT, 3'd0, 12'd0, 12'hFFF, 1'b0);
		send_item(OP_SAMPLE, ROW_LEFT, 3'd1, 12'hFFF, 12'd0, 1'b0);
		send_item(OP_SAMPLE, ROW_LEFT, 3'd2, 12'd2000, 12'd0, 1'b0);
		send_item(OP_SAMPLE, ROW_LEFT, 3'd7, 12'hFFF, 12'hFFF, 1'b0);
		send_item(OP_SAMPLE, ROW_LEFT, 3'd3, 12'd4000, 12'd0, 1'b0);
		send_item(OP_SAMPLE, ROW_RIGHT, 3'd0, 12'hFFF, 12'd0, 1'b0);
		send_item(OP_SAMPLE, ROW_RIGHT, 3'd3, 12'd0, 12'd0, 1'b0);
		send_item(OP_SAMPLE, ROW_RIGHT, 3'd4, 12'd50, 12'd0, 1'b0);
		send_item(OP_SAMPLE, ROW_RIGHT, 3'd1, 12'd1234, 12'd0, 1'b1);
		send_item(OP_SAMPLE, ROW_RIGHT, 3'd6, 12'hFFF, 12'd0, 1'b1);

		while (items_sent < DIRECTED + RANDOM_ITEMS) begin
			case ((items_sent - DIRECTED) * 4 / RANDOM_ITEMS)
				0: begin
					src_idle = 0;
					sink_stall = 0;
				end
				1: begin
					src_idle = 66;
					sink_stall = 0;
				end
				2: begin
					src_idle = 0;
					sink_stall = 66;
				end
				default: begin
					src_idle = 37;
					sink_stall = 37;
				end
			endcase
			kind = $urandom_range(99);
			if (kind < 12) begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					r = 1'($urandom_range(1));
					k = 3'($urandom_range(7));
					case ($urandom_range(3))
						0: begin
							lo = 12'($urandom);
							hi = 12'($urandom);
						end
						1: begin
							lo = $urandom_range(1) ? 12'hFFF : 12'($urandom);
							hi = lo;
						end
						2: begin
							lo = 12'($urandom_range(4095, 2048));
							hi = 12'($urandom_range(2047, 0));
						end
						default: begin
							lo = 12'($urandom_range(4000));
							hi = lo + 12'($urandom_range(8));
						end
					endcase
					calib(r, k, lo, hi, 1'($urandom_range(1)));
				end
			end else if (kind < 17) begin
				r = 1'($urandom_range(1));
				k = 3'($urandom_range(SPR - 1));
				calib(r, k, 12'hFFF, 12'hFFF, 1'b0);
				len = $urandom_range(18, 22);
				for (int j = 0; j < len; j++)
					send_item(OP_SAMPLE, r, k, 12'($urandom), 12'($urandom), j == len - 1);
			end else begin
				len = $urandom_range(1, 24);
				one_row = ($urandom_range(4) == 0);
				r0 = 1'($urandom_range(1));
				for (int j = 0; j < len; j++) begin
					r = one_row ? r0 : 1'($urandom_range(1));
					if ($urandom_range(9) == 0)
						k = 3'($urandom_range(7, SPR));
					else
						k = 3'($urandom_range(SPR - 1));
					if (k < SPR && !cal_seen[int'(r) * SPR + int'(k)])
						k = 3'(SPR);
					case ($urandom_range(3))
						0: v = 12'd0;
						1: v = 12'hFFF;
						default: v = 12'($urandom);
					endcase
					send_item(OP_SAMPLE, r, k, v, 12'($urandom), j == len - 1);
				end
			end
		end

		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/lse_pkg.sv
rtl/core/lse_in_if.sv
rtl/core/lse_out_if.sv
rtl/core/lse_ram.sv
rtl/core/lse_ctrl.sv
rtl/core/lse_dpath.sv
rtl/core/line_sensor_error.sv
test/lse_error_checker.sv
test/line_sensor_error_tb.sv
